@@ rtl/bytrun1_line_decoder_top_assert.svh @@
// Assertion macros used by the decoder core.
// Each use names a label, a property and a message; clk_i and rst_ni are taken
// from the module that expands the macro.
`ifndef BYTRUN1_LINE_DECODER_TOP_ASSERT_SVH
`define BYTRUN1_LINE_DECODER_TOP_ASSERT_SVH

`ifndef SYNTH

// Implication or plain property, checked at every rising edge outside reset.
`define BYTR1_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition that must never hold outside reset.
`define BYTR1_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define BYTR1_ASSERT(lbl, prop, msg)

`define BYTR1_NEVER(lbl, cond, msg)

`endif

`endif

@@ rtl/bytr1_pkg.sv @@
`timescale 1ns / 1ps

package bytr1_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LINE_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_COMPRESS_MODE = 2'd2;

  // Register values after reset.
  localparam logic [15:0] LINE_WIDTH_RST    = 16'd320;
  localparam logic [15:0] IMAGE_HEIGHT_RST  = 16'd200;
  localparam logic        COMPRESS_MODE_RST = 1'b1;

  // Compression modes.
  localparam logic MODE_RAW    = 1'b0;
  localparam logic MODE_PACKED = 1'b1;

  // Active configuration seen by the decoder.
  typedef struct packed {
    logic [15:0] line_width;
    logic [15:0] image_height;
    logic        compress_mode;
  } cfg_t;

  // One input beat.
  typedef struct packed {
    logic [7:0] chunk_byte;
    logic       new_image;
  } in_item_t;

  // One decoded record.
  typedef struct packed {
    logic [7:0]  pixel_value;
    logic [7:0]  repeat_count;
    logic [15:0] start_column;
    logic [15:0] row_index;
    logic        line_end;
    logic        image_end;
    logic        clipped;
  } record_t;

endpackage

@@ rtl/bytrun1_line_decoder_top.sv @@
`timescale 1ns / 1ps
// Channel    Dir  Beat contents
// s_axis     in   tdata: chunk_byte[7:0]; tuser: new_image
// m_axis     out  tdata: pixel_value, repeat_count, start_column, row_index;
//                 tuser: line_end, clipped; tlast: image_end
// cfg        in   cfg_index_i selects line_width, image_height or compress_mode
//
// One byte is taken per cycle while no stalled output beat holds the input register;
// a byte is held in the input register and its record, if any, is loaded into
// the output record register, with the decoder state update in between.
// Reset clears the decoder to row 0, column 0 and loads the register defaults.
// A stalled output beat holds; the input register still fills behind it.

module bytrun1_line_decoder_top
  import bytr1_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input beats.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] chunk_byte
  input  logic        s_axis_tuser,   // [0] new_image
  // Output beats.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] pixel_value, [15:8] repeat_count,
                                      // [31:16] start_column, [47:32] row_index
  output logic [1:0]  m_axis_tuser,   // [0] line_end, [1] clipped
  output logic        m_axis_tlast,   // image_end
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t     cfg_q;
  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     out_space;
  logic     advance;
  logic     rec_valid;
  record_t  rec;
  record_t  out_rec;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width    <= LINE_WIDTH_RST;
      cfg_q.image_height  <= IMAGE_HEIGHT_RST;
      cfg_q.compress_mode <= COMPRESS_MODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LINE_WIDTH:    cfg_q.line_width    <= cfg_data_i;
        CFG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data_i;
        CFG_COMPRESS_MODE: cfg_q.compress_mode <= cfg_data_i[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign in_item.chunk_byte = s_axis_tdata;
  assign in_item.new_image  = s_axis_tuser;

  // A held byte is decoded when the output register has room.
  assign advance = item_valid && out_space;

  bytr1_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .take_i     (advance),
    .valid_o    (item_valid),
    .item_o     (item)
  );

  bytr1_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  bytr1_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && rec_valid),
    .rec_i       (rec),
    .space_o     (out_space),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .rec_o       (out_rec)
  );

  assign m_axis_tdata = {out_rec.row_index, out_rec.start_column,
                         out_rec.repeat_count, out_rec.pixel_value};
  assign m_axis_tuser = {out_rec.clipped, out_rec.line_end};
  assign m_axis_tlast = out_rec.image_end;

endmodule

@@ rtl/bytr1_in_reg.sv @@
`timescale 1ns / 1ps

module bytr1_in_reg
  import bytr1_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  // The register takes a new beat when empty or when its item moves on.
  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

@@ rtl/bytr1_core.sv @@
`timescale 1ns / 1ps

module bytr1_core
  import bytr1_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output logic     rec_valid_o,
  output record_t  rec_o
);

`include "bytrun1_line_decoder_top_assert.svh"

  typedef enum logic [2:0] {
    PH_CONTROL,
    PH_REPEAT,
    PH_LITERAL,
    PH_SKIP,
    PH_PAD,
    PH_DONE
  } phase_e;

  localparam logic [7:0] CTRL_NOOP = 8'h80;

  phase_e      phase_q, phase_d, phase_cur;
  logic [7:0]  lit_q, lit_d, lit_cur, lit_dec;
  logic [7:0]  pend_q, pend_d, pend_cur;
  logic [15:0] col_q, col_d, col_cur;
  logic [15:0] row_q, row_d, row_cur;

  logic        emit;
  logic        clip_extra;
  logic [7:0]  want;
  logic [15:0] rem;
  logic [7:0]  cnt;
  logic        clip_run;
  logic [16:0] col_sum;
  logic        le, ie;
  logic [7:0]  b;

  assign b = item_i.chunk_byte;

  // A new image restarts the state before the byte is looked at.
  always_comb begin
    if (item_i.new_image) begin
      phase_cur = PH_CONTROL;
      lit_cur   = 8'd0;
      pend_cur  = 8'd0;
      col_cur   = 16'd0;
      row_cur   = 16'd0;
    end else begin
      phase_cur = phase_q;
      lit_cur   = lit_q;
      pend_cur  = pend_q;
      col_cur   = col_q;
      row_cur   = row_q;
    end
  end

  // Requested pixel count: the pending repeat, otherwise a single pixel.
  assign want = (cfg_i.compress_mode == MODE_PACKED && phase_cur == PH_REPEAT) ?
                pend_cur : 8'd1;

  // Record forming: clip to the rest of the row and find row and image ends.
  always_comb begin
    rem = (col_cur < cfg_i.line_width) ? (cfg_i.line_width - col_cur) : 16'd1;
    if ({8'd0, want} > rem) begin
      cnt      = rem[7:0];
      clip_run = 1'b1;
    end else begin
      cnt      = want;
      clip_run = 1'b0;
    end
    col_sum = {1'b0, col_cur} + {9'd0, cnt};
    le      = col_sum >= {1'b0, cfg_i.line_width};
    ie      = le && (({1'b0, row_cur} + 17'd1) >= {1'b0, cfg_i.image_height});
  end

  // Phase sequencing and state update for one byte.
  always_comb begin
    phase_d    = phase_cur;
    lit_d      = lit_cur;
    pend_d     = pend_cur;
    col_d      = col_cur;
    row_d      = row_cur;
    emit       = 1'b0;
    clip_extra = 1'b0;
    lit_dec    = lit_cur - 8'd1;

    if (phase_cur == PH_DONE) begin
      emit = 1'b0;
    end else if (cfg_i.compress_mode == MODE_RAW) begin
      if (phase_cur == PH_PAD) begin
        phase_d = PH_CONTROL;
      end else begin
        emit   = 1'b1;
        lit_d  = 8'd0;
        pend_d = 8'd0;
        if (ie) begin
          phase_d = PH_DONE;
        end else if (le && cfg_i.line_width[0]) begin
          phase_d = PH_PAD;
        end else begin
          phase_d = PH_CONTROL;
        end
      end
    end else begin
      unique case (phase_cur)
        PH_REPEAT: begin
          emit    = 1'b1;
          pend_d  = 8'd0;
          phase_d = ie ? PH_DONE : PH_CONTROL;
        end
        PH_LITERAL: begin
          emit = 1'b1;
          if (ie) begin
            lit_d   = 8'd0;
            phase_d = PH_DONE;
          end else if (le && lit_dec != 8'd0) begin
            // Row filled with literals still left: drop the rest of the group.
            lit_d      = lit_dec;
            clip_extra = 1'b1;
            phase_d    = PH_SKIP;
          end else begin
            lit_d   = lit_dec;
            phase_d = (lit_dec == 8'd0) ? PH_CONTROL : PH_LITERAL;
          end
        end
        PH_SKIP: begin
          lit_d   = lit_dec;
          phase_d = (lit_dec == 8'd0) ? PH_CONTROL : PH_SKIP;
        end
        default: begin
          // Control byte, also taken here after a stale pad phase.
          phase_d = PH_CONTROL;
          if (b == CTRL_NOOP) begin
            phase_d = PH_CONTROL;
          end else if (!b[7]) begin
            lit_d   = b + 8'd1;
            phase_d = PH_LITERAL;
          end else begin
            pend_d  = 8'd1 - b;
            phase_d = PH_REPEAT;
          end
        end
      endcase
    end

    // Position advance after a record.
    if (emit) begin
      if (le) begin
        col_d = 16'd0;
        if (!ie) begin
          row_d = row_cur + 16'd1;
        end
      end else begin
        col_d = col_sum[15:0];
      end
    end
  end

  assign rec_valid_o        = emit;
  assign rec_o.pixel_value  = b;
  assign rec_o.repeat_count = cnt;
  assign rec_o.start_column = col_cur;
  assign rec_o.row_index    = row_cur;
  assign rec_o.line_end     = le;
  assign rec_o.image_end    = ie;
  assign rec_o.clipped      = clip_run | clip_extra;

  // Decoder state, updated once for every byte that is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CONTROL;
      lit_q   <= 8'd0;
      pend_q  <= 8'd0;
      col_q   <= 16'd0;
      row_q   <= 16'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      pend_q  <= pend_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  // A finished image always leaves the column at zero.
  `BYTR1_ASSERT(a_done_col_zero, (phase_q == PH_DONE) |-> (col_q == 16'd0), "done with column")
  // Literal and skip phases always have bytes left to take.
  `BYTR1_NEVER(a_lit_nonzero, (phase_q == PH_LITERAL || phase_q == PH_SKIP) && lit_q == 8'd0,
               "literal phase with empty count")
  // A pending repeat is always between two and 128 pixels.
  `BYTR1_ASSERT(a_pend_range, (phase_q == PH_REPEAT) |-> (pend_q >= 8'd2 && pend_q <= 8'd128),
                "repeat count out of range")
  // Every emitted record covers at least one and at most 128 pixels.
  `BYTR1_ASSERT(a_cnt_range, (step_i && emit) |-> (cnt != 8'd0 && cnt <= 8'd128),
                "record count out of range")

endmodule

@@ rtl/bytr1_out_reg.sv @@
`timescale 1ns / 1ps

module bytr1_out_reg
  import bytr1_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  record_t rec_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output record_t rec_o
);

  logic    valid_q;
  record_t rec_q;

  // Room for a record when empty or when the held beat leaves this cycle.
  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

endmodule
